>>> sv/hcn_pkg.sv
// ----------------------------------------------------------------------------
// hcn_pkg
// shared types and constants of the cell block normalizer pipeline
// ----------------------------------------------------------------------------
package hcn_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned SumW        = 34;
  localparam int unsigned NormW       = 16;
  localparam int unsigned Lanes       = 4;
  localparam int unsigned DivSteps    = 2;
  localparam int unsigned DivStages   = DataW / DivSteps;
  localparam int unsigned SqrtSteps   = 2;
  localparam int unsigned SqrtStages  = NormW / SqrtSteps;
  // entry register, divider stages, root stages, output register
  localparam int unsigned Latency     = 1 + DivStages + SqrtStages + 1;
  localparam logic [NormW-1:0] NormSat = '1;

  typedef struct packed {
    logic zero;
    logic sat;
  } lane_flag_t;

  typedef struct packed {
    logic [SumW-1:0]  rem;
    logic [DataW-1:0] quo;
    logic [SumW-1:0]  bsum;
    lane_flag_t       flag;
  } div_t;

  typedef struct packed {
    logic [DataW-1:0] op;
    logic [DataW-1:0] res;
    lane_flag_t       flag;
  } sqrt_t;

endpackage

>>> sv/hcn_div_stage.sv
// ----------------------------------------------------------------------------
// hcn_div_stage
// one registered stage of the restoring divider, two quotient bits per stage
// ----------------------------------------------------------------------------
module hcn_div_stage (
  input  logic          clk_i,
  input  logic          en_i,
  input  hcn_pkg::div_t d_i,
  output hcn_pkg::div_t q_o
);
  import hcn_pkg::*;

  div_t             d_d;
  div_t             d_q;
  logic [SumW:0]    shifted;

  // shift in a zero, compare and subtract
  always_comb begin
    d_d     = d_i;
    shifted = '0;
    for (int j = 0; j < DivSteps; j++) begin
      shifted = {d_d.rem, 1'b0};
      if (shifted >= {1'b0, d_d.bsum}) begin
        d_d.rem = SumW'(shifted - {1'b0, d_d.bsum});
        d_d.quo = {d_d.quo[DataW-2:0], 1'b1};
      end else begin
        d_d.rem = shifted[SumW-1:0];
        d_d.quo = {d_d.quo[DataW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q <= d_d;
    end
  end

  assign q_o = d_q;

endmodule

>>> sv/hcn_sqrt_stage.sv
// ----------------------------------------------------------------------------
// hcn_sqrt_stage
// one registered stage of the digit-by-digit square root, two steps per stage
// ----------------------------------------------------------------------------
module hcn_sqrt_stage #(
  parameter int unsigned STAGE = 0
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  hcn_pkg::sqrt_t d_i,
  output hcn_pkg::sqrt_t q_o
);
  import hcn_pkg::*;

  sqrt_t            s_d;
  sqrt_t            s_q;
  logic [DataW-1:0] one;
  logic [DataW-1:0] trial;

  // test the next root bit and reduce the remainder
  always_comb begin
    s_d   = d_i;
    one   = '0;
    trial = '0;
    for (int j = 0; j < SqrtSteps; j++) begin
      one   = (DataW'(1) << (DataW - 2)) >> (2 * (SqrtSteps * STAGE + j));
      trial = s_d.res + one;
      if (s_d.op >= trial) begin
        s_d.op  = s_d.op - trial;
        s_d.res = (s_d.res >> 1) + one;
      end else begin
        s_d.res = s_d.res >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= s_d;
    end
  end

  assign q_o = s_q;

endmodule

>>> sv/hcn_lane.sv
// ----------------------------------------------------------------------------
// hcn_lane
// divider and square root chain for one block sum
// ----------------------------------------------------------------------------
module hcn_lane (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  hcn_pkg::div_t             d_i,
  output logic [hcn_pkg::NormW-1:0] norm_o
);
  import hcn_pkg::*;

  div_t  div_chain [DivStages+1];
  sqrt_t sqrt_chain [SqrtStages+1];

  assign div_chain[0] = d_i;

  // quotient bits, most significant first
  for (genvar i = 0; i < DivStages; i++) begin : g_div
    hcn_div_stage u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .d_i   (div_chain[i]),
      .q_o   (div_chain[i+1])
    );
  end

  // root of the quotient
  assign sqrt_chain[0].op   = div_chain[DivStages].quo;
  assign sqrt_chain[0].res  = '0;
  assign sqrt_chain[0].flag = div_chain[DivStages].flag;

  for (genvar i = 0; i < SqrtStages; i++) begin : g_sqrt
    hcn_sqrt_stage #(.STAGE(i)) u_sqrt (
      .clk_i (clk_i),
      .en_i  (en_i),
      .d_i   (sqrt_chain[i]),
      .q_o   (sqrt_chain[i+1])
    );
  end

  // special cases override the root
  always_comb begin
    if (sqrt_chain[SqrtStages].flag.zero) begin
      norm_o = '0;
    end else if (sqrt_chain[SqrtStages].flag.sat) begin
      norm_o = NormSat;
    end else begin
      norm_o = sqrt_chain[SqrtStages].res[NormW-1:0];
    end
  end

endmodule

>>> sv/hog_cell_l1_sqrt_normalizer_unit.sv
// ----------------------------------------------------------------------------
// hog_cell_l1_sqrt_normalizer_unit
// L1-sqrt normalization of one orientation bin against four 2x2 block sums
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request: the bin value and the nine neighborhood
//   cell totals, all 24.8 unsigned. m_axis returns the four normalized
//   values sqrt(bin / block_sum) as 0.16 fractions, saturated at 65535,
//   zero where the bin or the block sum is zero.
//   the accepted request passes through one entry register for the block
//   sums, 16 divider stages (2 quotient bits each), 8 root stages (2 root
//   bits each) and the output register.
//   throughput is one request per cycle while the receiver does not stall;
//   the whole pipeline advances as one and every stage holds a full request.
//   when the receiver stalls with a result waiting, the pipeline freezes and
//   s_axis_tready drops in the same cycle; nothing is lost or repeated.
//   reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module hog_cell_l1_sqrt_normalizer_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // bin_value, sum_nw, sum_n, sum_ne, sum_w, sum_c, sum_e, sum_sw, sum_s,
  // sum_se; 32 bits each from bit 0 up
  input  logic [319:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // norm_upleft, norm_upright, norm_downleft, norm_downright; 16 bits each
  output logic [63:0]  m_axis_tdata
);
  import hcn_pkg::*;

  localparam int unsigned PipeDepth = Latency - 1;

  logic                 en;
  logic [DataW-1:0]     bin_value;
  logic [DataW-1:0]     tot [9];
  logic [SumW-1:0]      bsum [Lanes];
  div_t                 entry_d [Lanes];
  div_t                 entry_q [Lanes];
  logic [NormW-1:0]     norm [Lanes];
  logic [PipeDepth-1:0] vld_q;
  logic [PipeDepth-1:0] vld_d;
  logic                 out_vld_q;
  logic [63:0]          out_data_q;

  // the pipeline moves whenever the output register can take a value
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // unpack request
  assign bin_value = s_axis_tdata[DataW-1:0];
  for (genvar k = 0; k < 9; k++) begin : g_tot
    assign tot[k] = s_axis_tdata[DataW*(k+1) +: DataW];
  end

  // block sums: nw n ne / w c e / sw s se
  assign bsum[0] = SumW'(tot[0]) + SumW'(tot[1]) + SumW'(tot[3]) + SumW'(tot[4]);
  assign bsum[1] = SumW'(tot[1]) + SumW'(tot[2]) + SumW'(tot[4]) + SumW'(tot[5]);
  assign bsum[2] = SumW'(tot[3]) + SumW'(tot[4]) + SumW'(tot[6]) + SumW'(tot[7]);
  assign bsum[3] = SumW'(tot[4]) + SumW'(tot[5]) + SumW'(tot[7]) + SumW'(tot[8]);

  // entry register per lane
  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    always_comb begin
      entry_d[l].rem       = SumW'(bin_value);
      entry_d[l].quo       = '0;
      entry_d[l].bsum      = bsum[l];
      entry_d[l].flag.zero = (bsum[l] == '0) || (bin_value == '0);
      entry_d[l].flag.sat  = SumW'(bin_value) >= bsum[l];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        entry_q[l] <= entry_d[l];
      end
    end

    hcn_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .d_i    (entry_q[l]),
      .norm_o (norm[l])
    );
  end

  // valid bits follow the data
  assign vld_d = {vld_q[PipeDepth-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= vld_d;
      out_vld_q <= vld_q[PipeDepth-1];
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {norm[3], norm[2], norm[1], norm[0]};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> sv/hcn_checker.sv
// ----------------------------------------------------------------------------
// hcn_checker
// port-level checks of the normalizer pipeline
// ----------------------------------------------------------------------------
module hcn_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready
);
  import hcn_pkg::*;

  localparam int unsigned CntW = $clog2(Latency + 2);

  logic            in_acc;
  logic            out_acc;
  logic [CntW-1:0] inflight_q;
  logic [CntW-1:0] inflight_d;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // requests accepted but not yet delivered
  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc) begin
      inflight_d = inflight_q + CntW'(1);
    end else if (!in_acc && out_acc) begin
      inflight_d = inflight_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // a waiting result freezes the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // no result without a request behind it
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (inflight_q != '0))
    else $error("result without pending request");

  // the pipeline never holds more than its depth
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(Latency))
    else $error("more requests in flight than pipeline stages");

  // a stalled result stays offered
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

endmodule

bind hog_cell_l1_sqrt_normalizer_unit hcn_checker u_hcn_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

>>> test/hog_cell_l1_sqrt_normalizer_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hog_cell_l1_sqrt_normalizer_unit_test
// checks the four block-normalized outputs of every request against a local
// predictor, under random idling on both sides, a long receiver hold-off and
// a drain pause on the sender
// ----------------------------------------------------------------------------

// scoreboard of expected normalized results
class norm_scoreboard;
  logic [63:0] pending_q[$];
  int          mismatches;

  // exact floor(65536 * sqrt(bin / bsum)) with zero and saturation cases
  static function logic [15:0] calc_norm(logic [33:0] bin, logic [33:0] bsum);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] t;
    if (bsum == 0 || bin == 0) return 16'h0;
    if (bin >= bsum) return 16'hFFFF;
    q = ({30'd0, bin} << 32) / {30'd0, bsum};
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= q) r = t;
    end
    return r[15:0];
  endfunction

  // note an accepted request
  function void note_request(logic [319:0] d);
    logic [33:0] f[10];
    logic [63:0] res;
    for (int i = 0; i < 10; i++) f[i] = {2'b00, d[32*i +: 32]};
    res[15:0]  = calc_norm(f[0], f[1] + f[2] + f[4] + f[5]);
    res[31:16] = calc_norm(f[0], f[2] + f[3] + f[5] + f[6]);
    res[47:32] = calc_norm(f[0], f[4] + f[5] + f[7] + f[8]);
    res[63:48] = calc_norm(f[0], f[5] + f[6] + f[8] + f[9]);
    pending_q.push_back(res);
  endfunction

  // check an accepted result against the oldest expectation
  function void check_result(logic [63:0] got);
    logic [63:0] want;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending_q.pop_front();
    for (int l = 0; l < 4; l++) begin
      if (got[16*l +: 16] !== want[16*l +: 16]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("lane %0d mismatch: expected %h actual %h", l,
                   want[16*l +: 16], got[16*l +: 16]);
      end
    end
  endfunction
endclass

module hog_cell_l1_sqrt_normalizer_unit_test;
  import hcn_pkg::*;

  localparam int RandItems = 1250;
  localparam int WatchLimit = 20000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [319:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;

  norm_scoreboard sb;
  logic        stim_done;
  logic        calm_phase;
  logic        hold_req;
  int          idle_cycles;

  hog_cell_l1_sqrt_normalizer_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // random 32-bit field biased toward extremes and small values
  function automatic logic [31:0] rand_field();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFFFFFF;
      2: return $urandom_range(0, 255);
      3: return $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  // drive one request and wait for its accept
  task automatic send_request(logic [319:0] d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(d);
  endtask

  // random sender gap
  task automatic sender_gap();
    int n;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 19);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_fields(logic [31:0] f[10]);
    logic [319:0] d;
    for (int i = 0; i < 10; i++) d[32*i +: 32] = f[i];
    send_request(d);
    sender_gap();
  endtask

  // receiver: random bursts of stall, plus a requested long hold-off
  initial begin
    int n;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk_i);
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 19);
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // watchdog on cycles without any accept
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [31:0] f[10];
    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    stim_done     = 1'b0;
    calm_phase    = 1'b0;
    hold_req      = 1'b0;
    idle_cycles   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: all zero, all max, zero bin, zero block sums, saturation
    foreach (f[i]) f[i] = 32'h0;
    send_fields(f);
    foreach (f[i]) f[i] = 32'hFFFFFFFF;
    send_fields(f);
    f[0] = 32'h0;
    send_fields(f);
    foreach (f[i]) f[i] = 32'h0;
    f[0] = 32'h1;
    send_fields(f);
    f[0] = 32'hFFFFFFFF; f[5] = 32'h1;
    send_fields(f);
    f[0] = 32'h1; f[5] = 32'hFFFFFFFF;
    send_fields(f);
    for (int k = 1; k < 10; k++) begin
      foreach (f[i]) f[i] = 32'h0;
      f[0] = 32'h100; f[k] = 32'h400;
      send_fields(f);
    end
    foreach (f[i]) f[i] = 32'h100;
    send_fields(f);
    f[0] = 32'h400;
    send_fields(f);
    f[0] = 32'h3FF;
    send_fields(f);
    foreach (f[i]) f[i] = 32'h1;
    f[0] = 32'hFFFFFFFF;
    send_fields(f);

    // random; long receiver hold-off early, sender drain pause midway
    for (int n = 0; n < RandItems; n++) begin
      if (n == 100) hold_req <= 1'b1;
      if (n == 130) hold_req <= 1'b0;
      if (n == 600) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (sb.pending_q.size() != 0) @(posedge clk_i);
      end
      if (n == RandItems - 150) calm_phase <= 1'b1;
      for (int i = 0; i < 10; i++) f[i] = rand_field();
      if ($urandom_range(0, 1)) begin
        // realistic bin, a fraction of its own cell total
        f[0] = f[5] >> $urandom_range(0, 8);
      end
      send_fields(f);
    end
    s_axis_tvalid <= 1'b0;
    stim_done <= 1'b1;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
